@@ hw/rtl/ddmc_pkg.sv @@
// ddmc_pkg: shared types and constants for the differential-drive motor command block.
// Register map, configuration struct and default parameters. No dependencies.
package ddmc_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int COMMAND_LIMIT_DEF = 1000;

    localparam int VEL_W  = 24;
    localparam int CMD_W  = 11;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    // register index, paddr[ADDR_W-1:2]
    typedef enum logic [2:0] {
        REG_MIN_ANG   = 3'd0,
        REG_MIN_LIN   = 3'd1,
        REG_MAX_WHEEL = 3'd2,
        REG_TRACK     = 3'd3,
        REG_CAL_L     = 3'd4,
        REG_CAL_R     = 3'd5,
        REG_CPM_L     = 3'd6,
        REG_CPM_R     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [19:0] min_angular_speed;
        logic [19:0] min_linear_speed;
        logic [19:0] max_wheel_speed;
        logic [19:0] track_width;
        logic [17:0] left_calibration;
        logic [17:0] right_calibration;
        logic [25:0] left_counts_per_mps;
        logic [25:0] right_counts_per_mps;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        min_angular_speed:    20'd3277,
        min_linear_speed:     20'd13107,
        max_wheel_speed:      20'd98304,
        track_width:          20'd30383,
        left_calibration:     18'd65313,
        right_calibration:    18'd65758,
        left_counts_per_mps:  26'd40264663,
        right_counts_per_mps: 26'd40264663
    };

endpackage

@@ hw/rtl/ddmc_if.sv @@
// ddmc_if: valid/ready channel interfaces for velocity commands and motor commands.
// Depends on ddmc_pkg for field widths.
interface ddmc_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [ddmc_pkg::VEL_W-1:0]   linear_velocity;
    logic signed [ddmc_pkg::VEL_W-1:0]   angular_velocity;

    modport source (output valid, kind, linear_velocity, angular_velocity, input ready);
    modport sink   (input valid, kind, linear_velocity, angular_velocity, output ready);
endinterface

interface ddmc_motor_if;
    logic                                valid;
    logic                                ready;
    logic signed [ddmc_pkg::CMD_W-1:0]   left_command;
    logic signed [ddmc_pkg::CMD_W-1:0]   right_command;
    logic                                command_limited;

    modport source (output valid, left_command, right_command, command_limited, input ready);
    modport sink   (input valid, left_command, right_command, command_limited, output ready);
endinterface

@@ hw/rtl/ddmc_regs.sv @@
// ddmc_regs: APB-style configuration register file.
// Depends on ddmc_pkg (t_cfg, t_reg_idx, CFG_RESET).
module ddmc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ddmc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ddmc_pkg::DATA_W-1:0]   pwdata,
    output logic [ddmc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output ddmc_pkg::t_cfg                o_cfg
);

    ddmc_pkg::t_cfg     r_cfg;
    ddmc_pkg::t_reg_idx idx;

    assign idx    = ddmc_pkg::t_reg_idx'(paddr[ddmc_pkg::ADDR_W-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ddmc_pkg::CFG_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                ddmc_pkg::REG_MIN_ANG:   r_cfg.min_angular_speed    <= pwdata[19:0];
                ddmc_pkg::REG_MIN_LIN:   r_cfg.min_linear_speed     <= pwdata[19:0];
                ddmc_pkg::REG_MAX_WHEEL: r_cfg.max_wheel_speed      <= pwdata[19:0];
                ddmc_pkg::REG_TRACK:     r_cfg.track_width          <= pwdata[19:0];
                ddmc_pkg::REG_CAL_L:     r_cfg.left_calibration     <= pwdata[17:0];
                ddmc_pkg::REG_CAL_R:     r_cfg.right_calibration    <= pwdata[17:0];
                ddmc_pkg::REG_CPM_L:     r_cfg.left_counts_per_mps  <= pwdata[25:0];
                ddmc_pkg::REG_CPM_R:     r_cfg.right_counts_per_mps <= pwdata[25:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ddmc_pkg::REG_MIN_ANG:   prdata = 32'(r_cfg.min_angular_speed);
            ddmc_pkg::REG_MIN_LIN:   prdata = 32'(r_cfg.min_linear_speed);
            ddmc_pkg::REG_MAX_WHEEL: prdata = 32'(r_cfg.max_wheel_speed);
            ddmc_pkg::REG_TRACK:     prdata = 32'(r_cfg.track_width);
            ddmc_pkg::REG_CAL_L:     prdata = 32'(r_cfg.left_calibration);
            ddmc_pkg::REG_CAL_R:     prdata = 32'(r_cfg.right_calibration);
            ddmc_pkg::REG_CPM_L:     prdata = 32'(r_cfg.left_counts_per_mps);
            ddmc_pkg::REG_CPM_R:     prdata = 32'(r_cfg.right_counts_per_mps);
            default:                 prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/ddmc_kin.sv @@
// ddmc_kin: seven-stage kinematics pipe, velocities to raw wheel counts.
// Minimum raise, turn term, calibration, wheel clamp, counts scaling. Uses ddmc_pkg.
module ddmc_kin #(
    parameter int FRACTION_BITS = ddmc_pkg::FRACTION_BITS_DEF,
    localparam int CW = 48 - FRACTION_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ddmc_pkg::t_cfg                       i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_kind,
    input  logic signed [ddmc_pkg::VEL_W-1:0]    i_lin,
    input  logic signed [ddmc_pkg::VEL_W-1:0]    i_ang,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [CW-1:0]                 o_cl,
    output logic signed [CW-1:0]                 o_cr,
    output logic                                 o_lim
);

    localparam int NS   = 7;
    localparam int V1W  = ddmc_pkg::VEL_W + 1;
    localparam int PW   = 46;
    localparam int TW   = PW - FRACTION_BITS;
    localparam int YW   = ((TW > V1W + 1) ? TW : V1W + 1) + 1;
    localparam int PRW  = YW + 19;
    localparam int WW   = 21;
    localparam int CPW  = 48;
    // smallest magnitude that is not treated as zero (1e-6 in real units)
    localparam int TINY = ((1 << FRACTION_BITS) + 999999) / 1000000;

    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;

    logic signed [V1W-1:0] r_v0, r_w0, n_v0, n_w0;
    logic signed [V1W-1:0] r_v1;
    logic signed [PW-1:0]  r_p1, n_p1;
    logic signed [YW-1:0]  r_yr2, r_yl2, n_yr2, n_yl2;
    logic signed [PRW-1:0] r_pr3, r_pl3, n_pr3, n_pl3;
    logic signed [WW-1:0]  r_wr4, r_wl4, n_wr4, n_wl4;
    logic                  r_lim4, n_lim4;
    logic signed [CPW-1:0] r_cpr5, r_cpl5, n_cpr5, n_cpl5;
    logic                  r_lim5, r_lim6;
    logic signed [CW-1:0]  r_cr6, r_cl6;

    // stall chain: a stage loads when empty or when it moves on
    always_comb begin
        rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: zero test and minimum raise
    always_comb begin
        logic signed [V1W-1:0] v, w;
        logic [V1W-1:0]        mv, mw, min_a, min_l;
        logic                  zv, zw;
        v     = i_kind ? '0 : V1W'(i_lin);
        w     = i_kind ? '0 : V1W'(i_ang);
        mv    = v[V1W-1] ? V1W'(-v) : V1W'(v);
        mw    = w[V1W-1] ? V1W'(-w) : V1W'(w);
        min_a = V1W'(i_cfg.min_angular_speed);
        min_l = V1W'(i_cfg.min_linear_speed);
        zv    = mv < V1W'(TINY);
        zw    = mw < V1W'(TINY);
        n_v0  = zv ? '0 : v;
        n_w0  = zw ? '0 : w;
        if (zv && !zw && (mw < min_a)) begin
            n_w0 = w[V1W-1] ? -$signed(min_a) : $signed(min_a);
        end else if (zw && !zv && (mv < min_l)) begin
            n_v0 = v[V1W-1] ? -$signed(min_l) : $signed(min_l);
        end
    end

    // stage 1: track * w
    assign n_p1 = $signed({1'b0, i_cfg.track_width}) * r_w0;

    // stage 2: 2v + floor(p / 2^F) right, 2v + floor(-p / 2^F) left
    always_comb begin
        logic signed [PW-1:0] neg_p;
        logic signed [TW-1:0] tr, tl;
        neg_p = -r_p1;
        tr    = TW'(r_p1 >>> FRACTION_BITS);
        tl    = TW'(neg_p >>> FRACTION_BITS);
        n_yr2 = (YW'(r_v1) <<< 1) + YW'(tr);
        n_yl2 = (YW'(r_v1) <<< 1) + YW'(tl);
    end

    // stage 3: calibration
    assign n_pr3 = $signed({1'b0, i_cfg.right_calibration}) * r_yr2;
    assign n_pl3 = $signed({1'b0, i_cfg.left_calibration}) * r_yl2;

    // stage 4: floor shift and wheel clamp
    always_comb begin
        logic signed [PRW-1:0] sr, sl, mx;
        sr     = r_pr3 >>> (FRACTION_BITS + 1);
        sl     = r_pl3 >>> (FRACTION_BITS + 1);
        mx     = PRW'($signed({1'b0, i_cfg.max_wheel_speed}));
        n_lim4 = 1'b0;
        n_wr4  = WW'(sr);
        n_wl4  = WW'(sl);
        if (sr > mx) begin
            n_wr4 = WW'(mx); n_lim4 = 1'b1;
        end else if (sr < -mx) begin
            n_wr4 = WW'(-mx); n_lim4 = 1'b1;
        end
        if (sl > mx) begin
            n_wl4 = WW'(mx); n_lim4 = 1'b1;
        end else if (sl < -mx) begin
            n_wl4 = WW'(-mx); n_lim4 = 1'b1;
        end
    end

    // stage 5: counts per m/s
    assign n_cpr5 = $signed({1'b0, i_cfg.right_counts_per_mps}) * r_wr4;
    assign n_cpl5 = $signed({1'b0, i_cfg.left_counts_per_mps}) * r_wl4;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_v0 <= n_v0; r_w0 <= n_w0;
        end
        if (rdy[1]) begin
            r_v1 <= r_v0; r_p1 <= n_p1;
        end
        if (rdy[2]) begin
            r_yr2 <= n_yr2; r_yl2 <= n_yl2;
        end
        if (rdy[3]) begin
            r_pr3 <= n_pr3; r_pl3 <= n_pl3;
        end
        if (rdy[4]) begin
            r_wr4 <= n_wr4; r_wl4 <= n_wl4; r_lim4 <= n_lim4;
        end
        if (rdy[5]) begin
            r_cpr5 <= n_cpr5; r_cpl5 <= n_cpl5; r_lim5 <= r_lim4;
        end
        if (rdy[6]) begin
            r_cr6  <= CW'(r_cpr5 >>> FRACTION_BITS);
            r_cl6  <= CW'(r_cpl5 >>> FRACTION_BITS);
            r_lim6 <= r_lim5;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_cl    = r_cl6;
    assign o_cr    = r_cr6;
    assign o_lim   = r_lim6;

    // clamped wheel speeds stay inside +/-max
    a_wheel_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r_wr4 <= $signed({1'b0, i_cfg.max_wheel_speed}))
                  && (r_wr4 >= -$signed({1'b0, i_cfg.max_wheel_speed}))
                  && (r_wl4 <= $signed({1'b0, i_cfg.max_wheel_speed}))
                  && (r_wl4 >= -$signed({1'b0, i_cfg.max_wheel_speed})))
        else $error("wheel speed outside clamp");

endmodule

@@ hw/rtl/ddmc_scale.sv @@
// ddmc_scale: command scaling pipe with a staged restoring divider, one quotient bit per stage.
// Takes raw counts, gives saturated motor commands. Uses ddmc_pkg.
module ddmc_scale #(
    parameter int FRACTION_BITS = ddmc_pkg::FRACTION_BITS_DEF,
    parameter int COMMAND_LIMIT = ddmc_pkg::COMMAND_LIMIT_DEF,
    localparam int CW = 48 - FRACTION_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [CW-1:0]                 i_cl,
    input  logic signed [CW-1:0]                 i_cr,
    input  logic                                 i_lim,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ddmc_pkg::CMD_W-1:0]    o_left,
    output logic signed [ddmc_pkg::CMD_W-1:0]    o_right,
    output logic                                 o_limited
);

    localparam int QW   = $clog2(COMMAND_LIMIT + 1);
    localparam int NW   = CW + QW;
    localparam int AW   = (CW - FRACTION_BITS > 1) ? CW - FRACTION_BITS : 1;
    localparam int VW0  = (QW > AW) ? QW : AW;
    localparam int VW   = (VW0 > ddmc_pkg::CMD_W + 1) ? VW0 : ddmc_pkg::CMD_W + 1;
    localparam int NS   = QW + 3;
    localparam int OUT_POS = (1 << (ddmc_pkg::CMD_W - 1)) - 1;
    localparam int OUT_NEG = 1 << (ddmc_pkg::CMD_W - 1);
    localparam int OUT_MAX = (COMMAND_LIMIT > OUT_POS) ? OUT_POS : COMMAND_LIMIT;
    localparam int OUT_MIN = (COMMAND_LIMIT > OUT_NEG) ? -OUT_NEG : -COMMAND_LIMIT;
    localparam logic [63:0] LIMF = 64'(COMMAND_LIMIT) << FRACTION_BITS;

    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;

    // stage 0
    logic [CW-1:0] r_mag_l0, r_mag_r0, r_m0, n_mag_l0, n_mag_r0, n_m0;
    logic          r_sl0, r_sr0, r_big0, r_lim0, n_big0;

    // divider section, index 0 is the dividend load, index j+1 follows step j
    logic [NW-1:0] r_rem_l [QW+1];
    logic [NW-1:0] r_rem_r [QW+1];
    logic [QW-1:0] r_q_l   [QW+1];
    logic [QW-1:0] r_q_r   [QW+1];
    logic [CW-1:0] r_m     [QW+1];
    logic [AW-1:0] r_alt_l [QW+1];
    logic [AW-1:0] r_alt_r [QW+1];
    logic          r_sl    [QW+1];
    logic          r_sr    [QW+1];
    logic          r_big   [QW+1];
    logic          r_lim   [QW+1];

    logic signed [ddmc_pkg::CMD_W-1:0] r_left, r_right;
    logic                              r_limited;
    logic [NW-1:0]                     n_nl, n_nr;

    function automatic logic signed [ddmc_pkg::CMD_W-1:0] sat(input logic neg,
                                                              input logic [VW-1:0] mg);
        logic signed [ddmc_pkg::CMD_W-1:0] res;
        if (!neg) begin
            res = (mg > VW'(OUT_POS)) ? ddmc_pkg::CMD_W'(OUT_POS) : ddmc_pkg::CMD_W'(mg);
        end else begin
            res = (mg > VW'(OUT_NEG)) ? ddmc_pkg::CMD_W'(OUT_NEG)
                                      : -(ddmc_pkg::CMD_W'(mg));
        end
        return res;
    endfunction

    always_comb begin
        rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: magnitudes, larger magnitude, limit test
    always_comb begin
        n_mag_l0 = i_cl[CW-1] ? CW'(-i_cl) : CW'(i_cl);
        n_mag_r0 = i_cr[CW-1] ? CW'(-i_cr) : CW'(i_cr);
        n_m0     = (n_mag_l0 > n_mag_r0) ? n_mag_l0 : n_mag_r0;
        n_big0   = 64'(n_m0) > LIMF;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_mag_l0 <= n_mag_l0; r_mag_r0 <= n_mag_r0; r_m0 <= n_m0;
            r_sl0 <= i_cl[CW-1]; r_sr0 <= i_cr[CW-1];
            r_big0 <= n_big0; r_lim0 <= i_lim;
        end
    end

    // stage 1: dividend = |c| * limit, plain path = |c| >> F
    assign n_nl = NW'(r_mag_l0) * NW'(COMMAND_LIMIT);
    assign n_nr = NW'(r_mag_r0) * NW'(COMMAND_LIMIT);

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_rem_l[0] <= n_nl;              r_rem_r[0] <= n_nr;
            r_q_l[0]   <= '0;                r_q_r[0]   <= '0;
            r_m[0]     <= r_m0;
            r_alt_l[0] <= AW'(r_mag_l0 >> FRACTION_BITS);
            r_alt_r[0] <= AW'(r_mag_r0 >> FRACTION_BITS);
            r_sl[0] <= r_sl0; r_sr[0] <= r_sr0; r_big[0] <= r_big0; r_lim[0] <= r_lim0;
        end
    end

    // stages 2..QW+1: one quotient bit each, MSB first
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int B = QW - 1 - j;
        logic [NW-1:0] d;
        logic          ge_l, ge_r;

        assign d    = NW'(r_m[j]) << B;
        assign ge_l = r_rem_l[j] >= d;
        assign ge_r = r_rem_r[j] >= d;

        always_ff @(posedge i_clk) begin
            if (rdy[j+2]) begin
                r_rem_l[j+1]    <= ge_l ? r_rem_l[j] - d : r_rem_l[j];
                r_rem_r[j+1]    <= ge_r ? r_rem_r[j] - d : r_rem_r[j];
                r_q_l[j+1]      <= r_q_l[j] | (QW'(ge_l) << B);
                r_q_r[j+1]      <= r_q_r[j] | (QW'(ge_r) << B);
                r_m[j+1]        <= r_m[j];
                r_alt_l[j+1]    <= r_alt_l[j];
                r_alt_r[j+1]    <= r_alt_r[j];
                r_sl[j+1]       <= r_sl[j];
                r_sr[j+1]       <= r_sr[j];
                r_big[j+1]      <= r_big[j];
                r_lim[j+1]      <= r_lim[j];
            end
        end
    end

    // output stage: pick path, restore sign, saturate
    always_ff @(posedge i_clk) begin
        if (rdy[NS-1]) begin
            r_left    <= sat(r_sl[QW], r_big[QW] ? VW'(r_q_l[QW]) : VW'(r_alt_l[QW]));
            r_right   <= sat(r_sr[QW], r_big[QW] ? VW'(r_q_r[QW]) : VW'(r_alt_r[QW]));
            r_limited <= r_lim[QW] | r_big[QW];
        end
    end

    assign o_ready   = rdy[0];
    assign o_valid   = r_vld[NS-1];
    assign o_left    = r_left;
    assign o_right   = r_right;
    assign o_limited = r_limited;

    // after the last step the remainders are below the divisor
    a_rem_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-2] && r_big[QW]) |-> (r_rem_l[QW] < NW'(r_m[QW])))
        else $error("left divider remainder not reduced");

    a_rem_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-2] && r_big[QW]) |-> (r_rem_r[QW] < NW'(r_m[QW])))
        else $error("right divider remainder not reduced");

    // commands never exceed the command limit
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(r_left) <= OUT_MAX) && (int'(r_left) >= OUT_MIN)
                 && (int'(r_right) <= OUT_MAX) && (int'(r_right) >= OUT_MIN))
        else $error("motor command outside limit");

endmodule

@@ hw/rtl/diff_drive_motor_command.sv @@
// diff_drive_motor_command: top level of the differential-drive motor command block.
// Instantiates ddmc_regs, ddmc_kin and ddmc_scale; uses ddmc_pkg and ddmc_if.
//
// Usage:
//   i_cmd (sink) takes one velocity command per transaction: kind (stop when 1),
//   linear and angular velocity in signed fixed point with FRACTION_BITS fraction bits.
//   o_motor (source) gives one transaction per command: left and right motor
//   commands (signed, truncated toward zero, within +/-COMMAND_LIMIT) and a flag
//   that is set when a wheel clamp or the command scaling took effect.
//   The APB port sets the eight configuration registers at byte address 4*index;
//   writes are meant to happen while no command is in flight.
// Timing:
//   A command passes through the ddmc_kin stages and then the ddmc_scale stages
//   from acceptance to o_motor.valid. Throughput is one command per cycle while
//   o_motor.ready stays high; each quotient bit of the scaling divide has a
//   pipeline stage of its own, so no unit is shared between commands.
// Reset and stall:
//   Reset empties the pipe and loads the register defaults.
//   When o_motor.ready is low the held result stays put and earlier stages keep
//   filling their empty slots; i_cmd.ready drops only once every stage holds a command.
module diff_drive_motor_command #(
    parameter int FRACTION_BITS = ddmc_pkg::FRACTION_BITS_DEF,
    parameter int COMMAND_LIMIT = ddmc_pkg::COMMAND_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ddmc_cmd_if.sink                      i_cmd,
    ddmc_motor_if.source                  o_motor,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ddmc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ddmc_pkg::DATA_W-1:0]   pwdata,
    output logic [ddmc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CW = 48 - FRACTION_BITS;

    ddmc_pkg::t_cfg        cfg;
    logic                  kin_valid, kin_ready, kin_lim;
    logic signed [CW-1:0]  kin_cl, kin_cr;

    // configuration registers, read live: the user must change them only while idle; the block does not enforce this
    ddmc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // velocities -> raw wheel counts with FRACTION_BITS fraction bits
    ddmc_kin #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_kin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_cmd.valid),
        .o_ready (i_cmd.ready),
        .i_kind  (i_cmd.kind),
        .i_lin   (i_cmd.linear_velocity),
        .i_ang   (i_cmd.angular_velocity),
        .o_valid (kin_valid),
        .i_ready (kin_ready),
        .o_cl    (kin_cl),
        .o_cr    (kin_cr),
        .o_lim   (kin_lim)
    );

    // raw counts -> limited, truncated motor commands
    ddmc_scale #(
        .FRACTION_BITS (FRACTION_BITS),
        .COMMAND_LIMIT (COMMAND_LIMIT)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (kin_valid),
        .o_ready   (kin_ready),
        .i_cl      (kin_cl),
        .i_cr      (kin_cr),
        .i_lim     (kin_lim),
        .o_valid   (o_motor.valid),
        .i_ready   (o_motor.ready),
        .o_left    (o_motor.left_command),
        .o_right   (o_motor.right_command),
        .o_limited (o_motor.command_limited)
    );

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for diff_drive_motor_command (velocity -> motor counts).
// Uses ddmc_pkg and the ddmc_cmd_if / ddmc_motor_if channels; APB writes set the registers.
// Random handshake gaps on both channels, results checked in order against a local predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB        = ddmc_pkg::FRACTION_BITS_DEF;
    localparam int CMD_LIM   = ddmc_pkg::COMMAND_LIMIT_DEF;
    localparam int MAX_CYCLES = 600000;

    typedef struct {
        bit                                kind;
        logic signed [ddmc_pkg::VEL_W-1:0] lin;
        logic signed [ddmc_pkg::VEL_W-1:0] ang;
    } t_vel_cmd;

    typedef struct {
        logic signed [ddmc_pkg::CMD_W-1:0] left;
        logic signed [ddmc_pkg::CMD_W-1:0] right;
        logic                              limited;
    } t_motor_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ddmc_pkg::ADDR_W-1:0] paddr = '0;
    logic [ddmc_pkg::DATA_W-1:0] pwdata = '0;
    logic [ddmc_pkg::DATA_W-1:0] prdata;
    logic pready;

    ddmc_cmd_if   cmd_ch();
    ddmc_motor_if motor_ch();

    diff_drive_motor_command DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_motor (motor_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ddmc_pkg::t_cfg cfg_shadow = ddmc_pkg::CFG_RESET;   // what the block's registers hold
    t_vel_cmd   pending_cmds[$];          // commands waiting to be sent
    t_motor_cmd expected_motor[$];        // predicted results, oldest first
    bit         errors = 1'b0;
    bit         no_gaps = 1'b0;           // burst stretches with no idling
    int         cycle_count = 0;

    // ---------------- predictor ----------------
    function automatic longint floor_sh(longint x, int k);
        return x >>> k;
    endfunction

    function automatic longint trunc_sh(longint x, int k);
        return (x >= 0) ? (x >>> k) : -((-x) >>> k);
    endfunction

    function automatic longint clamp_wheel(longint y, longint cal, longint mx, inout bit hit);
        longint s;
        s = floor_sh(cal * y, FB + 1);
        if (s > mx) begin
            s = mx;
            hit = 1'b1;
        end else if (s < -mx) begin
            s = -mx;
            hit = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [ddmc_pkg::CMD_W-1:0] sat_cmd(longint c);
        if (c > 1023) c = 1023;
        if (c < -1024) c = -1024;
        return c[ddmc_pkg::CMD_W-1:0];
    endfunction

    function automatic t_motor_cmd predict_motor(t_vel_cmd c);
        longint v, w, p, wr, wl, cl, cr, m, mx, ml, mr;
        longint min_ang, min_lin;
        bit hit;
        int zeros;
        t_motor_cmd r;
        hit = 1'b0;
        zeros = 0;
        v = c.kind ? 0 : longint'(c.lin);
        w = c.kind ? 0 : longint'(c.ang);
        min_ang = cfg_shadow.min_angular_speed;
        min_lin = cfg_shadow.min_linear_speed;
        // velocities under 1e-6 count as exactly zero
        if ((v < 0 ? -v : v) * 1000000 < (64'd1 << FB)) begin v = 0; zeros++; end
        if ((w < 0 ? -w : w) * 1000000 < (64'd1 << FB)) begin w = 0; zeros++; end
        // pure turn or pure drive: raise to the minimum, keeping the sign
        if (zeros == 1) begin
            if (v == 0 && (w < 0 ? -w : w) < min_ang)
                w = (w > 0) ? min_ang : -min_ang;
            else if (w == 0 && (v < 0 ? -v : v) < min_lin)
                v = (v > 0) ? min_lin : -min_lin;
        end
        p  = longint'(cfg_shadow.track_width) * w;
        mx = cfg_shadow.max_wheel_speed;
        wr = clamp_wheel(2 * v + floor_sh(p, FB), cfg_shadow.right_calibration, mx, hit);
        wl = clamp_wheel(2 * v + floor_sh(-p, FB), cfg_shadow.left_calibration, mx, hit);
        cl = floor_sh(wl * longint'(cfg_shadow.left_counts_per_mps), FB);
        cr = floor_sh(wr * longint'(cfg_shadow.right_counts_per_mps), FB);
        ml = cl < 0 ? -cl : cl;
        mr = cr < 0 ? -cr : cr;
        m  = ml > mr ? ml : mr;
        if (m > (longint'(CMD_LIM) << FB)) begin
            hit = 1'b1;
            r.left  = sat_cmd((cl * CMD_LIM) / m);
            r.right = sat_cmd((cr * CMD_LIM) / m);
        end else begin
            r.left  = sat_cmd(trunc_sh(cl, FB));
            r.right = sat_cmd(trunc_sh(cr, FB));
        end
        r.limited = hit;
        return r;
    endfunction

    // ---------------- idle gaps ----------------
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- command driver ----------------
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_vel_cmd c;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.kind <= 1'b0;
            cmd_ch.linear_velocity <= '0;
            cmd_ch.angular_velocity <= '0;
        end else begin
            // accepted transaction: predict with the registers now in force
            if (cmd_ch.valid && cmd_ch.ready) begin
                c.kind = cmd_ch.kind;
                c.lin  = cmd_ch.linear_velocity;
                c.ang  = cmd_ch.angular_velocity;
                expected_motor.push_back(predict_motor(c));
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    cmd_ch.valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    c = pending_cmds.pop_front();
                    cmd_ch.kind <= c.kind;
                    cmd_ch.linear_velocity <= c.lin;
                    cmd_ch.angular_velocity <= c.ang;
                    cmd_ch.valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result monitor ----------------
    int stall = 0;
    always @(posedge i_clk) begin
        t_motor_cmd e;
        if (!i_rst_n) begin
            motor_ch.ready <= 1'b0;
        end else begin
            if (motor_ch.valid && motor_ch.ready) begin
                if (expected_motor.size() == 0) begin
                    $display("%0t: unexpected transaction L=%0d R=%0d lim=%0b", $realtime,
                             motor_ch.left_command, motor_ch.right_command,
                             motor_ch.command_limited);
                    errors = 1'b1;
                end else begin
                    e = expected_motor.pop_front();
                    if (motor_ch.left_command !== e.left || motor_ch.right_command !== e.right
                            || motor_ch.command_limited !== e.limited) begin
                        $display({"%0t: mismatch expected L=%0d R=%0d lim=%0b,",
                                  " got L=%0d R=%0d lim=%0b"},
                                 $realtime, e.left, e.right, e.limited,
                                 motor_ch.left_command, motor_ch.right_command,
                                 motor_ch.command_limited);
                        errors = 1'b1;
                    end
                end
            end
            if (stall != 0) begin
                stall <= stall - 1;
                motor_ch.ready <= 1'b0;
            end else begin
                motor_ch.ready <= 1'b1;
                stall <= pick_gap();
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- APB and stimulus ----------------
    task automatic apb_write(ddmc_pkg::t_reg_idx idx, logic [ddmc_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ddmc_pkg::ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);  // register loads at this edge
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_config(ddmc_pkg::t_cfg c);
        apb_write(ddmc_pkg::REG_MIN_ANG,   32'(c.min_angular_speed));
        apb_write(ddmc_pkg::REG_MIN_LIN,   32'(c.min_linear_speed));
        apb_write(ddmc_pkg::REG_MAX_WHEEL, 32'(c.max_wheel_speed));
        apb_write(ddmc_pkg::REG_TRACK,     32'(c.track_width));
        apb_write(ddmc_pkg::REG_CAL_L,     32'(c.left_calibration));
        apb_write(ddmc_pkg::REG_CAL_R,     32'(c.right_calibration));
        apb_write(ddmc_pkg::REG_CPM_L,     32'(c.left_counts_per_mps));
        apb_write(ddmc_pkg::REG_CPM_R,     32'(c.right_counts_per_mps));
        cfg_shadow = c;
    endtask

    task automatic queue_cmd(bit kind, int lin, int ang);
        t_vel_cmd c;
        c.kind = kind;
        c.lin  = lin[ddmc_pkg::VEL_W-1:0];
        c.ang  = ang[ddmc_pkg::VEL_W-1:0];
        pending_cmds.push_back(c);
    endtask

    function automatic int rand_velocity();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $signed(24'($urandom));
        if (r < 7) return $signed(32'($urandom_range(0, 40000))) - 20000;
        if (r < 8) return 0;
        if (r < 9) return ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
        return $signed(32'($urandom_range(0, 400000))) - 200000;
    endfunction

    // wait until every command has gone through and the pipe has drained;
    // polled on the falling edge so the driver's updates have settled
    task automatic drain();
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_motor.size() != 0)
            @(negedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        ddmc_pkg::t_cfg c;
        int   ang;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 7; phase++) begin
            no_gaps = (phase == 3);
            case (phase)
                0: c = ddmc_pkg::CFG_RESET;
                1: c = '1;
                2: c = '0;
                3: begin
                    c = ddmc_pkg::CFG_RESET;
                    c.max_wheel_speed = 20'd4000;
                end
                default: c = ddmc_pkg::t_cfg'({$urandom, $urandom, $urandom, $urandom,
                                               $urandom, $urandom});
            endcase
            if (phase != 0) load_config(c);

            // directed: extremes, stop, min raise on either axis
            queue_cmd(0, 0, 0);
            queue_cmd(1, 8388607, -8388608);
            queue_cmd(0, 8388607, 0);
            queue_cmd(0, -8388608, 0);
            queue_cmd(0, 0, 8388607);
            queue_cmd(0, 0, -8388608);
            queue_cmd(0, 8388607, 8388607);
            queue_cmd(0, -8388608, -8388608);
            queue_cmd(0, 8388607, -8388608);
            queue_cmd(0, 1, 0);
            queue_cmd(0, -1, 0);
            queue_cmd(0, 0, 1);
            queue_cmd(0, 0, -1);
            queue_cmd(0, 5000, 0);
            queue_cmd(0, 0, -2000);
            queue_cmd(0, 1, -1);
            queue_cmd(0, 65536, 65536);
            queue_cmd(0, -65536, 131072);

            for (int n = 0; n < 140; n++) begin
                ang = rand_velocity();
                queue_cmd($urandom_range(0, 15) == 0, rand_velocity(), ang);
            end
            drain();
        end

        if (!errors) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/ddmc_pkg.sv
hw/rtl/ddmc_if.sv
hw/rtl/ddmc_regs.sv
hw/rtl/ddmc_kin.sv
hw/rtl/ddmc_scale.sv
hw/rtl/diff_drive_motor_command.sv
bench/tb.sv
